>>> rtl/core/rgbdc_pkg.sv
package rgbdc_pkg;

    // Default line buffer capacity in characters.
    localparam int LINE_CAPACITY_DEF = 32;

    // Configuration register map: the register index is paddr[2].
    localparam int          PADDR_W        = 3;
    localparam logic        REG_PERIOD_TOP = 1'b0;
    localparam logic [15:0] TOP_RESET      = 16'd999;

    // Characters recognized by the parser.
    localparam logic [7:0] CH_NUL  = 8'h00;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_D_LO = "d";
    localparam logic [7:0] CH_D_UP = "D";
    localparam logic [7:0] CH_R_LO = "r";
    localparam logic [7:0] CH_R_UP = "R";
    localparam logic [7:0] CH_G_LO = "g";
    localparam logic [7:0] CH_G_UP = "G";
    localparam logic [7:0] CH_B_LO = "b";
    localparam logic [7:0] CH_B_UP = "B";

    // Level = (c1 - '0') * 10 + (c2 - '0') modulo 256.
    // The two '0' offsets fold into 48 * 11 = 528, which is 16 modulo 256.
    localparam logic [7:0] LEVEL_MUL  = 8'd10;
    localparam logic [7:0] LEVEL_BIAS = 8'd16;

    // Product of period top and level magnitude fits in 23 bits.
    localparam int PROD_W = 23;

    // Division by 100 is a multiply by ceil(2^30 / 100), exact below 2^23 + 3.
    localparam int                RECIP_SHIFT = 30;
    localparam logic [23:0]       RECIP       = 24'd10737419;
    localparam int                QUOT_W      = 17;
    localparam logic [PROD_W-1:0] NEG_ROUND   = PROD_W'(3);
    // Low 16 bits of floor(2^32 / 100); a wrapped negative product divides
    // to this value minus floor((P + 3) / 100).
    localparam logic [QUOT_W-1:0] DUTY_WRAP   = QUOT_W'(23592);

    // Status codes of a closed line.
    localparam logic [2:0] STATUS_NONE       = 3'd0;
    localparam logic [2:0] STATUS_BLINK_ON   = 3'd1;
    localparam logic [2:0] STATUS_BLINK_OFF  = 3'd2;
    localparam logic [2:0] STATUS_BAD_LETTER = 3'd3;
    localparam logic [2:0] STATUS_TOO_SHORT  = 3'd4;

    // Operation decoded from one input item.
    typedef enum logic [2:0] {
        OP_IDLE,
        OP_TICK,
        OP_BLINK,
        OP_SET_RED,
        OP_SET_GREEN,
        OP_SET_BLUE,
        OP_BAD_LETTER,
        OP_TOO_SHORT
    } t_op;

    typedef struct packed {
        logic       cmd;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic        echo_valid;
        logic [7:0]  echo_byte;
        logic        line_done;
        logic [2:0]  status;
        logic [15:0] red_compare;
        logic [15:0] green_compare;
        logic [15:0] blue_compare;
        logic        blink_active;
    } t_out_item;

    // Decoded command handed from the line assembler to the apply stage.
    typedef struct packed {
        t_op               op;
        logic              echo_valid;
        logic [7:0]        echo_byte;
        logic              line_done;
        logic              neg;
        logic [PROD_W-1:0] prod;
    } t_line_cmd;

endpackage

>>> rtl/core/rgbdc_stream_if.sv
interface rgbdc_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

>>> rtl/core/rgbdc_line_assembler.sv
module rgbdc_line_assembler #(
    parameter int LINE_CAPACITY = rgbdc_pkg::LINE_CAPACITY_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  rgbdc_pkg::t_in_item   i_item,
    input  logic [15:0]           i_period_top,
    output rgbdc_pkg::t_line_cmd  o_cmd
);
    import rgbdc_pkg::*;

    localparam int               CNT_W       = $clog2(LINE_CAPACITY);
    localparam logic [CNT_W-1:0] CLOSE_COUNT = CNT_W'(LINE_CAPACITY - 1);

    logic [CNT_W-1:0] r_count, n_count;
    logic [2:0][7:0]  r_head, n_head;
    logic [1:0]       r_tlen, n_tlen;
    logic             r_nul, n_nul;

    logic [2:0][7:0]  e_head;
    logic [1:0]       e_tlen;
    logic             close;
    logic             echo;
    logic [7:0]       lvl;
    logic [7:0]       mag;
    logic [23:0]      prod_full;
    t_op              op;

    // Gather the byte into the line and decide whether the line closes.
    always_comb begin
        n_count = r_count;
        n_head  = r_head;
        n_tlen  = r_tlen;
        n_nul   = r_nul;
        e_head  = r_head;
        e_tlen  = r_tlen;
        close   = 1'b0;
        echo    = 1'b0;
        if (!i_item.cmd) begin
            if (i_item.rx_byte inside {CH_LF, CH_CR}) begin
                close = 1'b1;
            end else begin
                for (int k = 0; k < 3; k++) begin
                    if (r_count == CNT_W'(k)) begin
                        n_head[k] = i_item.rx_byte;
                    end
                end
                if (i_item.rx_byte == CH_NUL) begin
                    n_nul = 1'b1;
                end else if (!r_nul && r_tlen != 2'd3) begin
                    n_tlen = r_tlen + 2'd1;
                end
                n_count = r_count + CNT_W'(1);
                echo    = 1'b1;
                close   = (n_count >= CLOSE_COUNT);
                e_head  = n_head;
                e_tlen  = n_tlen;
            end
        end
        if (close) begin
            n_count = '0;
            n_head  = '0;
            n_tlen  = '0;
            n_nul   = 1'b0;
        end
    end

    // Classify the closed line.
    always_comb begin
        if (i_item.cmd) begin
            op = OP_TICK;
        end else if (!close || e_tlen == 2'd0) begin
            op = OP_IDLE;
        end else if (e_head[0] inside {CH_D_LO, CH_D_UP}) begin
            op = OP_BLINK;
        end else if (e_tlen == 2'd3) begin
            if (e_head[0] inside {CH_R_LO, CH_R_UP}) begin
                op = OP_SET_RED;
            end else if (e_head[0] inside {CH_G_LO, CH_G_UP}) begin
                op = OP_SET_GREEN;
            end else if (e_head[0] inside {CH_B_LO, CH_B_UP}) begin
                op = OP_SET_BLUE;
            end else begin
                op = OP_BAD_LETTER;
            end
        end else begin
            op = OP_TOO_SHORT;
        end
    end

    // Signed 8-bit level, its magnitude and the product with period top.
    always_comb begin
        lvl       = e_head[1] * LEVEL_MUL + e_head[2] - LEVEL_BIAS;
        mag       = lvl[7] ? 8'(-lvl) : lvl;
        prod_full = {8'd0, i_period_top} * {16'd0, mag};
    end

    assign o_cmd.op         = op;
    assign o_cmd.echo_valid = echo;
    assign o_cmd.echo_byte  = echo ? i_item.rx_byte : CH_NUL;
    assign o_cmd.line_done  = close;
    assign o_cmd.neg        = lvl[7] && (i_period_top != 16'd0);
    assign o_cmd.prod       = prod_full[PROD_W-1:0];

    // Line state advances on every accepted item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_head  <= '0;
            r_tlen  <= '0;
            r_nul   <= 1'b0;
        end else if (i_accept) begin
            r_count <= n_count;
            r_head  <= n_head;
            r_tlen  <= n_tlen;
            r_nul   <= n_nul;
        end
    end

    // A line never rests at the closing length.
    a_count_below_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < CLOSE_COUNT)
        else $error("line count reached the closing length");

    // A stored NUL means at least one character is in the line.
    a_nul_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nul |-> r_count != '0)
        else $error("NUL flag set on an empty line");

endmodule

>>> rtl/core/rgb_duty_command_parser.sv
// RGB duty command parser.
// Input channel i_cmd carries one transaction per received UART byte
// (cmd = 0) or per blink timer tick (cmd = 1). Output channel o_res returns
// exactly one transaction for every input transaction, in order: the echo
// of a stored byte, the line-close flag with its status code, and the three
// compare values and blink flag after the item has taken effect.
// The result of an accepted input transaction passes through the decode
// register and the result register before it shows on o_res.
// A new input transaction is accepted every cycle unless o_res stalls;
// the line assembly logic feeds the decode register at the accepting edge
// and the duty apply stage feeds the result register. The apply stage
// holds the one 23x24 multiply that divides the scaled level by 100.
// When o_res is stalled, one more item is taken into the decode register,
// after which i_cmd.ready drops until the result is taken.
// Reset (synchronous, active low) empties the line, clears all compares
// and the blink state, drains both stages and sets period_top to 999.
// period_top is written through the APB port at byte address 0; it is
// meant to be written only while no transaction is in flight.
module rgb_duty_command_parser #(
    parameter int LINE_CAPACITY = rgbdc_pkg::LINE_CAPACITY_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    rgbdc_stream_if.sink                    i_cmd,
    rgbdc_stream_if.source                  o_res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rgbdc_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import rgbdc_pkg::*;

    logic [15:0]      r_period_top;
    logic             r_s1_valid;
    t_line_cmd        r_s1;
    logic             r_out_valid;
    t_out_item        r_out;
    logic [15:0]      r_red, n_red;
    logic [15:0]      r_green, n_green;
    logic [15:0]      r_blue, n_blue;
    logic             r_blink, n_blink;
    logic             r_led, n_led;

    t_in_item         in_item;
    t_line_cmd        asm_cmd;
    logic             in_ready;
    logic             accept;
    logic             s1_move;
    logic             cfg_write;
    logic [PROD_W-1:0] div_in;
    logic [PROD_W+23:0] recip_prod;
    logic [QUOT_W-1:0] quot;
    logic [15:0]      duty;
    logic [2:0]       status;
    t_out_item        n_out;

    // Configuration port: single register, zero wait states.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_PERIOD_TOP);
    assign prdata    = (paddr[2] == REG_PERIOD_TOP) ? {16'd0, r_period_top} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_top <= TOP_RESET;
        end else if (cfg_write) begin
            r_period_top <= pwdata[15:0];
        end
    end

    // Pipeline flow control.
    assign s1_move     = r_s1_valid && (!r_out_valid || o_res.ready);
    assign in_ready    = !r_s1_valid || s1_move;
    assign accept      = i_cmd.valid && in_ready;
    assign i_cmd.ready = in_ready;
    assign in_item     = i_cmd.data;

    rgbdc_line_assembler #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_line (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_item       (in_item),
        .i_period_top (r_period_top),
        .o_cmd        (asm_cmd)
    );

    // Decode register between the assembler and the apply stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1 <= asm_cmd;
        end
    end

    // Divide the scaled level by 100; a negative level wraps at 32 bits.
    always_comb begin
        div_in     = r_s1.prod + (r_s1.neg ? NEG_ROUND : '0);
        recip_prod = {24'd0, div_in} * {{PROD_W{1'b0}}, RECIP};
        quot       = recip_prod[RECIP_SHIFT+QUOT_W-1:RECIP_SHIFT];
        duty       = r_s1.neg ? 16'(DUTY_WRAP - quot) : quot[15:0];
    end

    // Apply the decoded command to the compare and blink state.
    always_comb begin
        n_red   = r_red;
        n_green = r_green;
        n_blue  = r_blue;
        n_blink = r_blink;
        n_led   = r_led;
        status  = STATUS_NONE;
        case (r_s1.op)
            OP_TICK: begin
                if (r_blink) begin
                    n_led = !r_led;
                    n_red = r_led ? 16'd0 : r_period_top;
                end
            end
            OP_BLINK: begin
                n_blink = !r_blink;
                if (r_blink) begin
                    n_red  = 16'd0;
                    status = STATUS_BLINK_OFF;
                end else begin
                    status = STATUS_BLINK_ON;
                end
            end
            OP_SET_RED: begin
                n_red   = duty;
                n_blink = 1'b0;
            end
            OP_SET_GREEN: begin
                n_green = duty;
                n_blink = 1'b0;
            end
            OP_SET_BLUE: begin
                n_blue  = duty;
                n_blink = 1'b0;
            end
            OP_BAD_LETTER: status = STATUS_BAD_LETTER;
            OP_TOO_SHORT:  status = STATUS_TOO_SHORT;
            default:       status = STATUS_NONE;
        endcase

        n_out.echo_valid    = r_s1.echo_valid;
        n_out.echo_byte     = r_s1.echo_byte;
        n_out.line_done     = r_s1.line_done;
        n_out.status        = status;
        n_out.red_compare   = n_red;
        n_out.green_compare = n_green;
        n_out.blue_compare  = n_blue;
        n_out.blink_active  = n_blink;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red   <= '0;
            r_green <= '0;
            r_blue  <= '0;
            r_blink <= 1'b0;
            r_led   <= 1'b0;
        end else if (s1_move) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
            r_blink <= n_blink;
            r_led   <= n_led;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // With both stages full and the output stalled, no new item enters.
    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && !o_res.ready |-> !i_cmd.ready)
        else $error("input accepted while both stages are full");

    // A tick with blinking off leaves red untouched.
    a_tick_idle_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move && r_s1.op == OP_TICK && !r_blink |=> $stable(r_red))
        else $error("red changed on a tick while blink is off");

    // Turning blinking off clears red.
    a_blink_off_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_move && r_s1.op == OP_BLINK && r_blink |=> r_red == 16'd0 && !r_blink)
        else $error("blink off did not clear red");

    // A status code is reported only with a closed line.
    a_status_on_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.line_done || r_out.status == STATUS_NONE)
        else $error("status reported without a closed line");

endmodule
